// File: rtl/xcfr_pkg.sv
// Shared types and constants of the XOR-checked frame receiver.
// Used by every module under rtl/ but xcfr_ram; depends on nothing.
package xcfr_pkg;

    localparam int MAX_WORDS_DEF = 8;
    localparam int JOBQ_DEPTH = 2;

    localparam logic [7:0] START_MARK = 8'hAA;
    localparam logic [7:0] NODE_ID_RST = 8'd2;

    // Word address bit paddr[2] selects the register.
    localparam logic REG_NODE_ID = 1'b0;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ID,
        PH_LEN,
        PH_DATA,
        PH_CHECK
    } phase_t;

    // Job queue status seen by the parser and the word reader.
    typedef struct packed {
        logic full;
        logic valid;
    } jq_stat_t;

endpackage

// File: rtl/xor_checked_frame_receiver_core.sv
// Top level of the XOR-checked frame receiver: config register and wiring.
// Uses xcfr_pkg, xcfr_front, xcfr_jobq, xcfr_back and xcfr_ram.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+--------------------------------------
//   byte in   | push / full             | rx_byte[7:0]
//   word out  | pop / empty             | word_value[15:0] s, word_index[2:0],
//             |                         | last_word
//   config    | psel penable pwrite ... | paddr[2:0], pwdata, prdata (32 bit)
//
// Bytes are taken one per cycle while full is low. Each decoded word costs
// one read of the payload RAM, and only one read is in flight at a time:
// a new read waits until the last has landed. The RAM holds two frame
// banks; full rises while two good frames still wait to be drained, since
// the parser has no free bank to write. Reset is asynchronous, active low,
// and needs no clearing pass; node_id resets to 2.
module xor_checked_frame_receiver_core #(
    parameter int MAX_WORDS = xcfr_pkg::MAX_WORDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // byte input queue side
    input  logic               push,
    output logic               full,
    input  logic [7:0]         rx_byte,
    // word output queue side
    input  logic               pop,
    output logic               empty,
    output logic signed [15:0] word_value,
    output logic [2:0]         word_index,
    output logic               last_word,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import xcfr_pkg::*;

    localparam int STORE_BYTES = 2 * MAX_WORDS;
    localparam int CNT_W = $clog2(STORE_BYTES + 1) - 1;
    localparam int WA_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    // One address bit picks the bank, the rest the word within it.
    localparam int RAM_DEPTH = 2 ** (WA_W + 1);

    logic [7:0] node_id_reg;
    logic       cfg_wr;

    jq_stat_t   jq_stat;
    logic       job_push;
    logic       job_bank;
    logic [CNT_W-1:0] job_words;
    logic       job_pop;
    logic       head_bank;
    logic [CNT_W-1:0] head_words;

    logic            ram_we;
    logic [WA_W:0]   ram_waddr;
    logic [15:0]     ram_wdata;
    logic            ram_re;
    logic [WA_W:0]   ram_raddr;
    logic [15:0]     ram_rdata;

    // Config register: written in the access phase, always ready.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NODE_ID);
    assign prdata = (paddr[2] == REG_NODE_ID) ? {24'd0, node_id_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= NODE_ID_RST;
        end
        else if (cfg_wr)
        begin
            node_id_reg <= pwdata[7:0];
        end
    end

    // The parser stalls only on a full job queue (both banks claimed).
    assign full = jq_stat.full;

    xcfr_front #(
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rx_byte   (rx_byte),
        .node_id   (node_id_reg),
        .jq_stat   (jq_stat),
        .job_push  (job_push),
        .job_bank  (job_bank),
        .job_words (job_words),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    xcfr_jobq #(
        .MAX_WORDS (MAX_WORDS)
    ) u_jobq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_bank  (job_bank),
        .push_words (job_words),
        .pop        (job_pop),
        .stat       (jq_stat),
        .head_bank  (head_bank),
        .head_words (head_words)
    );

    xcfr_ram #(
        .WIDTH (16),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    xcfr_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .jq_stat    (jq_stat),
        .job_bank   (head_bank),
        .job_words  (head_words),
        .job_pop    (job_pop),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .pop        (pop),
        .empty      (empty),
        .word_value (word_value),
        .word_index (word_index),
        .last_word  (last_word)
    );

`ifndef SYNTHESIS
    // A frame is only committed when a queue slot is free.
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !jq_stat.full)
        else $error("job pushed into full queue");

    // Parser and reader never touch the same bank in one cycle.
    a_bank_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr[WA_W] != ram_raddr[WA_W]))
        else $error("RAM write and read hit the same bank");

    // A waiting word that is not the last keeps its frame in the queue.
    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last_word) |-> jq_stat.valid)
        else $error("frame retired before its last word");
`endif

endmodule

// File: rtl/xcfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module xcfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/xcfr_front.sv
// Byte parser: start hunt, id, length, payload into RAM, checksum check.
// Uses xcfr_pkg; pushes one job per good frame into xcfr_jobq.
module xcfr_front #(
    parameter int MAX_WORDS = xcfr_pkg::MAX_WORDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           node_id,
    input  xcfr_pkg::jq_stat_t   jq_stat,
    output logic                 job_push,
    output logic                 job_bank,
    output logic [$clog2(2*MAX_WORDS+1)-2:0] job_words,
    output logic                 ram_we,
    output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1):0] ram_waddr,
    output logic [15:0]          ram_wdata
);
    import xcfr_pkg::*;

    localparam int STORE_BYTES = 2 * MAX_WORDS;
    localparam int LEN_W = $clog2(STORE_BYTES + 1);
    localparam int WA_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    phase_t           phase_reg, phase_next;
    logic             bank_reg;
    logic [7:0]       frame_id_reg, frame_id_next;
    logic [LEN_W-1:0] frame_len_reg, frame_len_next;
    logic [LEN_W-1:0] taken_reg, taken_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       hi_reg, hi_next;

    logic             accept;
    logic [LEN_W-1:0] taken_inc;
    logic             len_ok;
    logic             frame_good;

    assign accept     = push && !jq_stat.full;
    assign taken_inc  = taken_reg + LEN_W'(1);
    assign len_ok     = (rx_byte <= 8'(STORE_BYTES));
    assign job_words  = frame_len_reg[LEN_W-1:1];
    assign frame_good = (xor_reg == rx_byte) && (frame_id_reg == node_id)
                        && (job_words != '0);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == START_MARK)
                    begin
                        phase_next = PH_ID;
                    end
                end
                PH_ID:
                begin
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (!len_ok)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else if (rx_byte == 8'd0)
                    begin
                        phase_next = PH_CHECK;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (taken_inc >= frame_len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // Per-phase datapath updates and outputs
    always_comb
    begin
        frame_id_next  = frame_id_reg;
        frame_len_next = frame_len_reg;
        taken_next     = taken_reg;
        xor_next       = xor_reg;
        hi_next        = hi_reg;
        ram_we         = 1'b0;
        job_push       = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                PH_ID:
                begin
                    frame_id_next = rx_byte;
                    xor_next      = rx_byte;
                end
                PH_LEN:
                begin
                    xor_next = xor_reg ^ rx_byte;
                    if (len_ok)
                    begin
                        frame_len_next = rx_byte[LEN_W-1:0];
                        taken_next     = '0;
                    end
                end
                PH_DATA:
                begin
                    taken_next = taken_inc;
                    xor_next   = xor_reg ^ rx_byte;
                    if (!taken_reg[0])
                    begin
                        hi_next = rx_byte;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                    end
                end
                PH_CHECK:
                begin
                    job_push = frame_good;
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    assign job_bank  = bank_reg;
    assign ram_waddr = {bank_reg, taken_reg[WA_W:1]};
    assign ram_wdata = {hi_reg, rx_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            bank_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (job_push)
            begin
                bank_reg <= ~bank_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        frame_id_reg  <= frame_id_next;
        frame_len_reg <= frame_len_next;
        taken_reg     <= taken_next;
        xor_reg       <= xor_next;
        hi_reg        <= hi_next;
    end

endmodule

// File: rtl/xcfr_jobq.sv
// Two-entry queue of accepted frames (RAM bank and word count).
// Uses xcfr_pkg; sits between xcfr_front and xcfr_back.
module xcfr_jobq #(
    parameter int MAX_WORDS = xcfr_pkg::MAX_WORDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 push_bank,
    input  logic [$clog2(2*MAX_WORDS+1)-2:0] push_words,
    input  logic                 pop,
    output xcfr_pkg::jq_stat_t   stat,
    output logic                 head_bank,
    output logic [$clog2(2*MAX_WORDS+1)-2:0] head_words
);
    import xcfr_pkg::*;

    localparam int CNT_W = $clog2(2 * MAX_WORDS + 1) - 1;
    localparam int PTR_W = $clog2(JOBQ_DEPTH);
    localparam int OCC_W = $clog2(JOBQ_DEPTH + 1);

    logic             bank_mem  [JOBQ_DEPTH];
    logic [CNT_W-1:0] words_mem [JOBQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OCC_W-1:0] occ_reg;

    assign stat.valid = (occ_reg != '0);
    assign stat.full  = (occ_reg == OCC_W'(JOBQ_DEPTH));
    assign head_bank  = bank_mem[rd_ptr_reg];
    assign head_words = words_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            bank_mem[wr_ptr_reg]  <= push_bank;
            words_mem[wr_ptr_reg] <= push_words;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                occ_reg <= occ_reg + OCC_W'(1);
            end
            else if (pop && !push)
            begin
                occ_reg <= occ_reg - OCC_W'(1);
            end
        end
    end

endmodule

// File: rtl/xcfr_back.sv
// Word reader: walks the head job's RAM bank and fills the output register.
// Uses xcfr_pkg; reads through xcfr_ram, retires jobs in xcfr_jobq.
module xcfr_back #(
    parameter int MAX_WORDS = xcfr_pkg::MAX_WORDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  xcfr_pkg::jq_stat_t   jq_stat,
    input  logic                 job_bank,
    input  logic [$clog2(2*MAX_WORDS+1)-2:0] job_words,
    output logic                 job_pop,
    output logic                 ram_re,
    output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1):0] ram_raddr,
    input  logic [15:0]          ram_rdata,
    input  logic                 pop,
    output logic                 empty,
    output logic signed [15:0]   word_value,
    output logic [2:0]           word_index,
    output logic                 last_word
);
    import xcfr_pkg::*;

    localparam int CNT_W = $clog2(2 * MAX_WORDS + 1) - 1;
    localparam int WA_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    logic [CNT_W-1:0]   k_reg;
    logic [CNT_W-1:0]   k_inc;
    logic               is_last;
    logic               issue;
    logic               pend_reg;
    logic [2:0]         pend_idx_reg;
    logic               pend_last_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_word_reg;
    logic [2:0]         out_idx_reg;
    logic               out_last_reg;

    // One read in flight; the output slot is free by the time data lands.
    assign issue     = jq_stat.valid && !pend_reg && (!out_valid_reg || pop);
    assign k_inc     = k_reg + CNT_W'(1);
    assign is_last   = (k_inc == job_words);
    assign job_pop   = issue && is_last;
    assign ram_re    = issue;
    assign ram_raddr = {job_bank, k_reg[WA_W-1:0]};

    assign empty      = !out_valid_reg;
    assign word_value = out_word_reg;
    assign word_index = out_idx_reg;
    assign last_word  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
            if (issue)
            begin
                k_reg <= is_last ? '0 : k_inc;
            end
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_idx_reg  <= 3'(k_reg);
            pend_last_reg <= is_last;
        end
        if (pend_reg)
        begin
            out_word_reg <= $signed(ram_rdata);
            out_idx_reg  <= pend_idx_reg;
            out_last_reg <= pend_last_reg;
        end
    end

endmodule

// File: tb/xor_checked_frame_receiver_core_tb.sv
// Testbench for xor_checked_frame_receiver_core: drives framed serial bytes, predicts
// decoded words in a local frame decoder and checks every popped word in order.
// Depends on rtl/xcfr_pkg.sv and the receiver RTL only.
`timescale 1ns / 100ps

module xor_checked_frame_receiver_core_tb;
    import xcfr_pkg::*;

    localparam int WORDS       = MAX_WORDS_DEF;
    localparam int STORE_BYTES = 2 * WORDS;
    // register 0 sits at byte address 0; paddr[2] picks the register
    localparam logic [2:0] NODE_ID_ADDR = {REG_NODE_ID, 2'b00};
    // cycles allowed for in-flight work after the last expected word
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic signed [15:0] value;
        logic [2:0]         index;
        logic               last;
    } word_t;

    typedef logic [7:0] byte_q_t[$];

    // DUT ports; the driven inputs are known from time zero
    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               push    = 1'b0;
    logic               full;
    logic [7:0]         rx_byte = 8'h00;
    logic               pop     = 1'b0;
    logic               empty;
    logic signed [15:0] word_value;
    logic [2:0]         word_index;
    logic               last_word;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [2:0]         paddr   = 3'd0;
    logic [31:0]        pwdata  = 32'd0;
    logic [31:0]        prdata;
    logic               pready;

    xor_checked_frame_receiver_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .pop        (pop),
        .empty      (empty),
        .word_value (word_value),
        .word_index (word_index),
        .last_word  (last_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame decoder model: own copy of parser state and node id
    // ------------------------------------------------------------------
    phase_t     rx_phase     = PH_HUNT;
    logic [7:0] rx_id        = 8'h00;
    logic [4:0] rx_len       = 5'd0;
    logic [4:0] rx_taken     = 5'd0;
    logic [7:0] rx_xor       = 8'h00;
    logic [7:0] rx_store [STORE_BYTES];
    logic [7:0] dev_id_shadow = NODE_ID_RST;

    word_t   expected_words[$];   // decoded words not yet popped
    byte_q_t byte_backlog;        // bytes waiting for the driver

    int error_count    = 0;
    int bytes_accepted = 0;
    int words_checked  = 0;
    int frames_queued  = 0;

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endfunction

    // Advance the decoder by one accepted byte; a good checksum byte on a frame
    // with the current node id appends the frame's words to expected_words.
    function automatic void decode_byte(input logic [7:0] b);
        int    n_words;
        word_t w;
        case (rx_phase)
            PH_HUNT:
                if (b == START_MARK)
                    rx_phase = PH_ID;
            PH_ID:
            begin
                rx_id    = b;
                rx_xor   = b;
                rx_phase = PH_LEN;
            end
            PH_LEN:
            begin
                rx_xor ^= b;
                if (b > STORE_BYTES)
                    rx_phase = PH_HUNT;       // oversize length: drop
                else
                begin
                    rx_len   = b[4:0];
                    rx_taken = 5'd0;
                    if (b == 8'd0)
                        rx_phase = PH_CHECK;  // empty frame skips data
                    else
                        rx_phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (rx_taken < STORE_BYTES)
                    rx_store[rx_taken] = b;
                rx_taken++;
                rx_xor ^= b;
                if (rx_taken >= rx_len)
                    rx_phase = PH_CHECK;
            end
            PH_CHECK:
            begin
                if (rx_xor == b && rx_id == dev_id_shadow)
                begin
                    // odd trailing byte is dropped by the integer divide
                    n_words = rx_len / 2;
                    for (int k = 0; k < n_words; k++)
                    begin
                        w.value = {rx_store[2 * k], rx_store[2 * k + 1]};
                        w.index = k[2:0];
                        w.last  = (k + 1 == n_words);
                        expected_words.push_back(w);
                    end
                end
                rx_phase = PH_HUNT;
            end
            default:
                rx_phase = PH_HUNT;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: bursts of random length with random gaps
    // ------------------------------------------------------------------
    int burst_left = 8;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push    <= 1'b0;
            rx_byte <= 8'h00;
        end
        else
        begin : drive
            logic       next_push;
            logic [7:0] next_byte;
            next_push = push;
            next_byte = rx_byte;
            if (push && !full)
            begin
                decode_byte(rx_byte);
                bytes_accepted++;
                void'(byte_backlog.pop_front());
            end
            // an offered item stays up unchanged until taken
            if (!(push && full))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    next_push = 1'b0;
                end
                else if (byte_backlog.size() != 0)
                begin
                    next_push = 1'b1;
                    next_byte = byte_backlog[0];
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 32);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            4, 5, 6, 7: gap_left = $urandom_range(1, 4);
                            8:          gap_left = $urandom_range(5, 12);
                            default:    gap_left = $urandom_range(20, 40);
                        endcase
                    end
                    else
                        burst_left--;
                end
                else
                    next_push = 1'b0;
            end
            push    <= next_push;
            rx_byte <= next_byte;
        end
    end

    // ------------------------------------------------------------------
    // Word monitor: pop follows an 8-bit mask, reshuffled after every fourth pass through it
    // ------------------------------------------------------------------
    logic [7:0] stall_mask = 8'hFF;
    int         stall_pos  = 0;
    int         stall_lap  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin : watch
            word_t want;
            if (pop && !empty)
            begin
                words_checked++;
                if (expected_words.size() == 0)
                    note_error($sformatf("unexpected word value=%0d index=%0d last=%0b",
                                         word_value, word_index, last_word));
                else
                begin
                    want = expected_words.pop_front();
                    if (word_value !== want.value || word_index !== want.index ||
                        last_word !== want.last)
                        note_error($sformatf(
                            "word mismatch: exp value=%0d index=%0d last=%0b, got %0d %0d %0b",
                            want.value, want.index, want.last,
                            word_value, word_index, last_word));
                end
            end
            stall_pos = (stall_pos + 1) % 8;
            if (stall_pos == 0)
            begin
                stall_lap++;
                if (stall_lap % 4 == 0)
                    case ($urandom_range(0, 3))
                        0:       stall_mask = 8'hFF;   // drain flat out
                        1:       stall_mask = 8'($urandom_range(0, 255));
                        2:       stall_mask = 8'h01;   // mostly stalled
                        default: stall_mask = 8'h00;   // long stall
                    endcase
            end
            pop <= stall_mask[stall_pos];
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue one frame; an oversize length ends it after the length byte.
    // Returns the number of words it should yield under the current id.
    function automatic int queue_frame(input logic [7:0] id, input logic [7:0] len,
                                       input byte_q_t data, input bit bad_sum);
        logic [7:0] sum;
        frames_queued++;
        byte_backlog.push_back(START_MARK);
        byte_backlog.push_back(id);
        byte_backlog.push_back(len);
        if (len > STORE_BYTES)
            return 0;
        sum = id ^ len;
        foreach (data[i])
        begin
            byte_backlog.push_back(data[i]);
            sum ^= data[i];
        end
        if (bad_sum)
            sum ^= 8'($urandom_range(1, 255));
        byte_backlog.push_back(sum);
        return (!bad_sum && id == dev_id_shadow) ? len / 2 : 0;
    endfunction

    // Mostly well-formed frames with random content, plus line noise
    // (biased toward the start mark so it breaks frames apart).
    function automatic void queue_random_batch(input int min_bytes, input int min_words);
        int         first;
        int         words_est;
        logic [7:0] id;
        logic [7:0] len;
        byte_q_t    data;
        first     = byte_backlog.size();
        words_est = 0;
        while ((byte_backlog.size() - first < min_bytes || words_est < min_words) &&
               byte_backlog.size() - first < 400)
        begin
            if ($urandom_range(0, 99) < 15)
                repeat ($urandom_range(1, 4))
                    if ($urandom_range(0, 2) == 0)
                        byte_backlog.push_back(START_MARK);
                    else
                        byte_backlog.push_back(8'($urandom_range(0, 255)));
            id = ($urandom_range(0, 9) < 8) ? dev_id_shadow : 8'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0:       len = 8'($urandom_range(0, 1));
                1, 2:    len = 8'(STORE_BYTES);
                3:       len = 8'($urandom_range(STORE_BYTES + 1, 255));
                default: len = 8'($urandom_range(2, STORE_BYTES));
            endcase
            data.delete();
            if (len <= STORE_BYTES)
                repeat (len)
                    data.push_back(8'($urandom_range(0, 255)));
            words_est += queue_frame(id, len, data, $urandom_range(0, 9) == 0);
        end
    endfunction

    // Block until the driver has nothing left and every word has come,
    // then let the receiver finish anything still in flight.
    task automatic wait_idle();
        @(negedge clk);
        while (byte_backlog.size() != 0 || push || expected_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // APB write of node_id, then a read back of the same register.
    task automatic set_node_id(input logic [7:0] id);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= NODE_ID_ADDR;
        pwdata  <= {24'd0, id};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);                 // write lands on this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        dev_id_shadow = id;
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);                 // access phase: read data valid
        if (prdata[7:0] !== dev_id_shadow)
            note_error($sformatf("node id read back 0x%02h, exp 0x%02h",
                                 prdata[7:0], dev_id_shadow));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        byte_q_t     none;
        byte_q_t     odd_data;
        byte_q_t     one_data;
        logic [7:0]  id_plan[4];
        none     = {};
        odd_data = {8'h80, 8'h00, 8'h7F, 8'hFF, 8'h33};
        one_data = {8'h12};
        id_plan  = '{8'h00, 8'hFF, START_MARK, 8'($urandom_range(0, 255))};

        // Directed frames at the reset node id
        byte_backlog.push_back(8'h00);                       // stray byte while hunting
        void'(queue_frame(NODE_ID_RST, 8'd0, none, 1'b0));     // empty good frame
        void'(queue_frame(8'h03, 8'd0, none, 1'b0));           // foreign id
        void'(queue_frame(NODE_ID_RST, 8'd17, none, 1'b0));    // oversize length
        void'(queue_frame(NODE_ID_RST, 8'd5, odd_data, 1'b0)); // min/max words + odd tail
        void'(queue_frame(NODE_ID_RST, 8'd1, one_data, 1'b0)); // one byte: no word
        void'(queue_frame(NODE_ID_RST, 8'd0, none, 1'b1));     // bad checksum

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // Random traffic under several ids; the full drain between
        // batches also parks the sender until every word is home.
        foreach (id_plan[i])
        begin
            set_node_id(id_plan[i]);
            queue_random_batch(20, 6);
            wait_idle();
        end

        if (expected_words.size() != 0)
            note_error($sformatf("%0d words never arrived", expected_words.size()));

        $display("Covered %0d bytes in %0d frames, %0d words popped and checked.",
                 bytes_accepted, frames_queued, words_checked);
        $display("Node ids used: reset value, 0x00, 0xFF, 0xAA and 0x%02h; %0d errors.",
                 id_plan[3], error_count);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Hard stop, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d words outstanding", expected_words.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
